// ===== design/wdc_pkg.sv =====
package wdc_pkg;

	localparam int HDR_LEN = 44;
	localparam int HDR_AW = 6;
	localparam int RIFF_EXTRA = 36;
	localparam int QDEPTH_DEF = 4;

	localparam logic [HDR_AW-1:0] HDR_LAST = HDR_AW'(HDR_LEN - 1);
	localparam logic [HDR_AW-1:0] HDR_CNT = HDR_AW'(HDR_LEN);

	localparam logic [1:0] SC_MONO8 = 2'd0;
	localparam logic [1:0] SC_MONO16 = 2'd1;
	localparam logic [1:0] SC_STEREO8 = 2'd2;
	localparam logic [1:0] SC_STEREO16 = 2'd3;

	typedef enum logic [1:0] {
		MODE_COLLECT = 2'd0,
		MODE_DATA = 2'd1,
		MODE_RAW = 2'd2
	} mode_t;

	typedef enum logic {
		BK_IDLE,
		BK_REPLAY
	} bk_state_t;

	typedef enum logic {
		ENT_SAMPLE,
		ENT_REPLAY
	} ent_kind_t;

	typedef struct packed {
		ent_kind_t kind;
		logic signed [16:0] num;
		logic [1:0] code;
		logic ok;
		logic sl;
		logic [HDR_AW-1:0] cnt;
	} entry_t;

	function automatic logic signed [16:0] raw_num(input logic [7:0] b);
		return $signed({8'd0, b, 1'b0}) - 17'sd255;
	endfunction

endpackage

// ===== design/wdc_byte_if.sv =====
interface wdc_byte_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic file_end;

	modport source(output valid, data_byte, file_end, input ready);
	modport sink(input valid, data_byte, file_end, output ready);
endinterface

// ===== design/wdc_sample_if.sv =====
interface wdc_sample_if;
	logic valid;
	logic ready;
	logic signed [16:0] sample_numerator;
	logic [1:0] scale_code;
	logic header_ok;
	logic run_last;
	logic stream_last;

	modport source(output valid, sample_numerator, scale_code, header_ok, run_last, stream_last,
		input ready);
	modport sink(input valid, sample_numerator, scale_code, header_ok, run_last, stream_last,
		output ready);
endinterface

// ===== design/wdc_ram.sv =====
module wdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 44
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/wdc_fifo.sv =====
module wdc_fifo import wdc_pkg::*; #(
	parameter int DEPTH = QDEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input entry_t push_ent,
	output logic full,
	input logic pop,
	output entry_t pop_ent,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_ent = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/wdc_front.sv =====
module wdc_front import wdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	wdc_byte_if.sink byte_in,
	output logic push,
	output entry_t push_ent,
	input logic q_full,
	input logic replay_done,
	output logic wr_en,
	output logic [HDR_AW-1:0] wr_addr,
	output logic [7:0] wr_data
);

	mode_t mode_q;
	mode_t mode_d;
	logic [HDR_AW-1:0] pos_q;
	logic [31:0] rem_q;
	logic stereo_q;
	logic [23:0] part_q;
	logic [1:0] pcnt_q;
	logic chk_q;
	logic rp_q;
	logic [31:0] riff_q;
	logic [31:0] rate_q;
	logic [31:0] br_q;
	logic [15:0] align_q;
	logic [15:0] bits_q;
	logic [23:0] dlen_q;

	logic [7:0] b;
	logic e;
	logic acc;
	logic collect;
	logic [HDR_AW-1:0] pos_c;
	logic hdr_end;
	logic [8:0] fx;
	logic step_ok;
	logic chk_d;
	logic [31:0] prod;
	logic [18:0] align_x8;
	logic [18:0] bits_x_ch;
	logic [31:0] dlen_full;
	logic [31:0] riff_exp;
	logic [1:0] amask;
	logic hdr_ok;
	logic bps2;
	logic [2:0] align_c;
	logic emit;
	logic signed [15:0] s_lo;
	logic signed [15:0] s_hi;
	logic signed [16:0] num_d;
	logic [1:0] code_d;

	// constant bytes of the canonical header: {fixed, value}
	function automatic logic [8:0] fixed_byte(input logic [HDR_AW-1:0] p);
		logic [8:0] r;
		r = 9'h000;
		unique case (p)
			6'd0: r = 9'h152;
			6'd1: r = 9'h149;
			6'd2: r = 9'h146;
			6'd3: r = 9'h146;
			6'd8: r = 9'h157;
			6'd9: r = 9'h141;
			6'd10: r = 9'h156;
			6'd11: r = 9'h145;
			6'd12: r = 9'h166;
			6'd13: r = 9'h16D;
			6'd14: r = 9'h174;
			6'd15: r = 9'h120;
			6'd16: r = 9'h110;
			6'd17: r = 9'h100;
			6'd18: r = 9'h100;
			6'd19: r = 9'h100;
			6'd20: r = 9'h101;
			6'd21: r = 9'h100;
			6'd23: r = 9'h100;
			6'd36: r = 9'h164;
			6'd37: r = 9'h161;
			6'd38: r = 9'h174;
			6'd39: r = 9'h161;
			default: r = 9'h000;
		endcase
		return r;
	endfunction

	assign b = byte_in.data_byte;
	assign e = byte_in.file_end;
	assign collect = (mode_q != MODE_DATA) && (mode_q != MODE_RAW);
	assign byte_in.ready = !q_full && !(collect && rp_q);
	assign acc = byte_in.valid && byte_in.ready;
	assign pos_c = (pos_q >= HDR_LAST) ? HDR_LAST : pos_q;
	assign hdr_end = (pos_c == HDR_LAST);

	assign wr_en = acc && collect;
	assign wr_addr = pos_c;
	assign wr_data = b;

	// header checks, folded in one byte at a time
	always_comb begin
		fx = fixed_byte(pos_c);
		prod = 32'(rate_q * align_q);
		align_x8 = {align_q, 3'b000};
		bits_x_ch = stereo_q ? {2'b00, bits_q, 1'b0} : {3'b000, bits_q};
		step_ok = !fx[8] || (b == fx[7:0]);
		if (pos_c == 6'd22) begin
			step_ok = (b == 8'd1) || (b == 8'd2);
		end
		if (pos_c == 6'd34) begin
			step_ok = (prod == br_q);
		end
		if (pos_c == 6'd36) begin
			step_ok = step_ok && (align_x8 == bits_x_ch) && ((bits_q == 16'd8) || (bits_q == 16'd16));
		end
		chk_d = ((pos_c == '0) ? 1'b1 : chk_q) && step_ok;
		dlen_full = {b, dlen_q};
		riff_exp = dlen_full + 32'(RIFF_EXTRA);
		amask = align_q[2] ? 2'b11 : (align_q[1] ? 2'b01 : 2'b00);
		hdr_ok = chk_d && (riff_q == riff_exp) && ((dlen_full[1:0] & amask) == 2'b00);
	end

	// sample assembly and downmix
	always_comb begin
		bps2 = (bits_q == 16'd16);
		align_c = {bps2 && stereo_q, bps2 != stereo_q, !bps2 && !stereo_q};
		emit = ({1'b0, pcnt_q} + 3'd1) >= align_c;
		s_lo = $signed(part_q[15:0]);
		s_hi = bps2 && !stereo_q ? $signed({b, part_q[7:0]}) : $signed({b, part_q[23:16]});
		unique case ({bps2, stereo_q})
			2'b00: begin
				num_d = raw_num(b);
				code_d = SC_MONO8;
			end
			2'b10: begin
				num_d = {s_hi, 1'b1};
				code_d = SC_MONO16;
			end
			2'b01: begin
				num_d = $signed({8'd0, part_q[7:0], 1'b0}) + $signed({8'd0, b, 1'b0}) - 17'sd510;
				code_d = SC_STEREO8;
			end
			default: begin
				num_d = 17'(s_lo) + 17'(s_hi) + 17'sd1;
				code_d = SC_STEREO16;
			end
		endcase
	end

	always_comb begin
		mode_d = mode_q;
		push = 1'b0;
		push_ent.kind = ENT_SAMPLE;
		push_ent.num = raw_num(b);
		push_ent.code = SC_MONO8;
		push_ent.ok = 1'b0;
		push_ent.sl = e;
		push_ent.cnt = HDR_CNT;
		unique case (mode_q)
			MODE_RAW: begin
				push = acc;
			end
			MODE_DATA: begin
				if (rem_q != '0 && emit) begin
					push = acc;
					push_ent.num = num_d;
					push_ent.code = code_d;
					push_ent.ok = 1'b1;
					push_ent.sl = e || (rem_q == 32'd1);
				end
			end
			default: begin
				if (hdr_end) begin
					if (hdr_ok) begin
						mode_d = MODE_DATA;
					end else begin
						push = acc;
						push_ent.kind = ENT_REPLAY;
						mode_d = MODE_RAW;
					end
				end else if (e) begin
					push = acc;
					push_ent.kind = ENT_REPLAY;
					push_ent.sl = 1'b1;
					push_ent.cnt = pos_c + 1'b1;
				end
			end
		endcase
		if (e) begin
			mode_d = MODE_COLLECT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_COLLECT;
		end else if (acc) begin
			mode_q <= mode_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			rem_q <= '0;
			part_q <= '0;
			pcnt_q <= '0;
			chk_q <= 1'b0;
			rp_q <= 1'b0;
			stereo_q <= 1'b0;
			bits_q <= 16'd8;
		end else begin
			if (replay_done) begin
				rp_q <= 1'b0;
			end
			if (push && push_ent.kind == ENT_REPLAY) begin
				rp_q <= 1'b1;
			end
			if (acc) begin
				unique case (mode_q)
					MODE_RAW: begin
						pos_q <= pos_q;
					end
					MODE_DATA: begin
						if (rem_q != '0) begin
							rem_q <= rem_q - 32'd1;
							if (emit) begin
								part_q <= '0;
								pcnt_q <= '0;
							end else begin
								if (pcnt_q != 2'd3) begin
									part_q[{pcnt_q, 3'b000} +: 8] <= b;
								end
								pcnt_q <= pcnt_q + 2'd1;
							end
						end
					end
					default: begin
						chk_q <= chk_d;
						if (pos_c == 6'd22) begin
							stereo_q <= (b == 8'd2);
						end
						if (pos_c[HDR_AW-1:2] == 4'd8) begin
							if (pos_c[1]) begin
								bits_q[{pos_c[0], 3'b000} +: 8] <= b;
							end
						end
						if (hdr_end) begin
							rem_q <= dlen_full;
							part_q <= '0;
							pcnt_q <= '0;
						end else begin
							pos_q <= pos_c + 1'b1;
						end
					end
				endcase
				if (e) begin
					pos_q <= '0;
					rem_q <= '0;
					part_q <= '0;
					pcnt_q <= '0;
				end
			end
		end
	end

	// header fields, payload only
	always_ff @(posedge clk) begin
		if (acc && collect) begin
			unique case (pos_c[HDR_AW-1:2])
				4'd1: riff_q[{pos_c[1:0], 3'b000} +: 8] <= b;
				4'd6: rate_q[{pos_c[1:0], 3'b000} +: 8] <= b;
				4'd7: br_q[{pos_c[1:0], 3'b000} +: 8] <= b;
				4'd8: begin
					if (!pos_c[1]) begin
						align_q[{pos_c[0], 3'b000} +: 8] <= b;
					end
				end
				4'd10: begin
					if (pos_c[1:0] != 2'd3) begin
						dlen_q[{pos_c[1:0], 3'b000} +: 8] <= b;
					end
				end
				default: riff_q <= riff_q;
			endcase
		end
	end

endmodule

// ===== design/wdc_back.sv =====
module wdc_back import wdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input entry_t q_ent,
	output logic pop,
	output logic rd_en,
	output logic [HDR_AW-1:0] rd_addr,
	input logic [7:0] rd_data,
	output logic replay_done,
	wdc_sample_if.source sample_out
);

	bk_state_t st_q;
	bk_state_t st_d;
	logic [HDR_AW-1:0] cnt_q;
	logic [HDR_AW-1:0] idx_q;
	logic [HDR_AW-1:0] didx_q;
	logic end_q;
	logic rdv_q;
	logic ov_q;
	logic signed [16:0] num_q;
	logic [1:0] code_q;
	logic ok_q;
	logic rl_q;
	logic sl_q;

	logic out_free;
	logic start;
	logic ld_ent;
	logic ld_rep;
	logic rep_last;

	assign out_free = !ov_q || sample_out.ready;
	assign rep_last = (didx_q == cnt_q - 1'b1);
	assign rd_addr = idx_q;

	always_comb begin
		st_d = st_q;
		pop = 1'b0;
		start = 1'b0;
		ld_ent = 1'b0;
		ld_rep = 1'b0;
		rd_en = 1'b0;
		replay_done = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				if (!q_empty) begin
					if (q_ent.kind == ENT_REPLAY) begin
						pop = 1'b1;
						start = 1'b1;
						st_d = BK_REPLAY;
					end else if (out_free) begin
						pop = 1'b1;
						ld_ent = 1'b1;
					end
				end
			end
			BK_REPLAY: begin
				ld_rep = rdv_q && out_free;
				rd_en = (idx_q != cnt_q) && (!rdv_q || ld_rep);
				if (ld_rep && rep_last) begin
					replay_done = 1'b1;
					st_d = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			didx_q <= '0;
			end_q <= 1'b0;
			rdv_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (start) begin
				cnt_q <= q_ent.cnt;
				end_q <= q_ent.sl;
				idx_q <= '0;
				rdv_q <= 1'b0;
			end else begin
				if (rd_en) begin
					idx_q <= idx_q + 1'b1;
					didx_q <= idx_q;
				end
				rdv_q <= rd_en || (rdv_q && !ld_rep);
			end
			if (ld_ent || ld_rep) begin
				ov_q <= 1'b1;
			end else if (sample_out.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_ent) begin
			num_q <= q_ent.num;
			code_q <= q_ent.code;
			ok_q <= q_ent.ok;
			rl_q <= 1'b1;
			sl_q <= q_ent.sl;
		end else if (ld_rep) begin
			num_q <= raw_num(rd_data);
			code_q <= SC_MONO8;
			ok_q <= 1'b0;
			rl_q <= rep_last;
			sl_q <= rep_last && end_q;
		end
	end

	assign sample_out.valid = ov_q;
	assign sample_out.sample_numerator = num_q;
	assign sample_out.scale_code = code_q;
	assign sample_out.header_ok = ok_q;
	assign sample_out.run_last = rl_q;
	assign sample_out.stream_last = sl_q;

endmodule

// ===== design/wav_header_check_pcm_downmix_core.sv =====
// channel     dir  payload
// byte_in     in   data_byte[7:0], file_end
// sample_out  out  sample_numerator[16:0] signed, scale_code[1:0], header_ok, run_last,
//                  stream_last
//
// one byte transfer per cycle while collecting the header, streaming data or raw bytes
// when the queue has room; a sample is queued, then loaded into the output register
// a replay of held header bytes (up to 44) starts when it reaches the queue head, then
// gives one result per cycle from the header ram while the receiver is ready
// a new file waits until the last replayed byte has left the header ram
// the result queue between front and back is QDEPTH entries; output stalls fill it
// arst_n returns the block to the start of a file; header ram contents are not cleared
module wav_header_check_pcm_downmix_core import wdc_pkg::*; #(
	parameter int QDEPTH = QDEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	wdc_byte_if.sink byte_in,
	wdc_sample_if.source sample_out
);

	logic push;
	entry_t push_ent;
	logic q_full;
	logic pop;
	entry_t pop_ent;
	logic q_empty;
	logic replay_done;
	logic wr_en;
	logic [HDR_AW-1:0] wr_addr;
	logic [7:0] wr_data;
	logic rd_en;
	logic [HDR_AW-1:0] rd_addr;
	logic [7:0] rd_data;

	wdc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(byte_in),
		.push(push),
		.push_ent(push_ent),
		.q_full(q_full),
		.replay_done(replay_done),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	wdc_fifo #(
		.DEPTH(QDEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_ent(push_ent),
		.full(q_full),
		.pop(pop),
		.pop_ent(pop_ent),
		.empty(q_empty)
	);

	wdc_ram #(
		.WIDTH(8),
		.DEPTH(HDR_LEN)
	) u_hdr_ram (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	wdc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_ent(pop_ent),
		.pop(pop),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.replay_done(replay_done),
		.sample_out(sample_out)
	);

endmodule

// ===== bench/wav_header_check_pcm_downmix_core_tb.sv =====
`timescale 1ns / 100ps

module wav_header_check_pcm_downmix_core_tb;
	import wdc_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 64;
	localparam int ITEM_GOAL = 260;
	localparam int KIND_ORDER [10] = '{5, 1, 2, 3, 0, 9, 4, 6, 7, 8};

	typedef struct packed {
		logic signed [16:0] num;
		logic [1:0] code;
		logic ok;
		logic rl;
		logic sl;
	} sample_t;

	class sample_board;
		logic [7:0] hdr [HDR_LEN];
		int pos;
		mode_t phase;
		logic [31:0] remaining;
		int chans;
		int bits;
		logic [23:0] partial;
		int pcount;
		sample_t expected [$];
		int errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			pos = 0;
			phase = MODE_COLLECT;
			remaining = '0;
			chans = 1;
			bits = 8;
			partial = '0;
			pcount = 0;
		endfunction

		function int byte_level(logic [7:0] v);
			return 2 * int'(v) - 255;
		endfunction

		function int s16(logic [15:0] w);
			return int'($signed(w));
		endfunction

		function logic [15:0] le16(int at);
			return {hdr[at + 1], hdr[at]};
		endfunction

		function logic [31:0] le32(int at);
			return {hdr[at + 3], hdr[at + 2], hdr[at + 1], hdr[at]};
		endfunction

		function logic [31:0] tag(int at);
			return {hdr[at], hdr[at + 1], hdr[at + 2], hdr[at + 3]};
		endfunction

		function void push(int num, logic [1:0] code, logic ok, logic rl, logic sl);
			sample_t s;
			s.num = num[16:0];
			s.code = code;
			s.ok = ok;
			s.rl = rl;
			s.sl = sl;
			expected.push_back(s);
		endfunction

		function bit header_passes();
			logic [31:0] nch, align, nbits, dlen, rate_product;
			if (tag(0) != "RIFF" || tag(8) != "WAVE" || tag(12) != "fmt " || tag(36) != "data")
				return 1'b0;
			if (le32(16) != 32'd16 || le16(20) != 16'd1)
				return 1'b0;
			nch = le16(22);
			align = le16(32);
			nbits = le16(34);
			dlen = le32(40);
			if (nch < 1 || nch > 2)
				return 1'b0;
			rate_product = le32(24) * align;
			if (le32(28) != rate_product)
				return 1'b0;
			if (le32(4) != dlen + 32'(RIFF_EXTRA))
				return 1'b0;
			if (align * 32'd8 != nbits * nch)
				return 1'b0;
			if (nbits != 8 && nbits != 16)
				return 1'b0;
			if (align == 0 || dlen % align != 0)
				return 1'b0;
			chans = nch;
			bits = nbits;
			remaining = dlen;
			return 1'b1;
		endfunction

		// held header bytes go out as raw mono samples
		function void replay(int count, logic e);
			for (int k = 0; k < count; k++)
				push(byte_level(hdr[k]), SC_MONO8, 1'b0, k == count - 1, (k == count - 1) && e);
		endfunction

		function void note_byte(logic [7:0] b, logic e);
			int at, bps, align, num;
			logic [1:0] code;
			case (phase)
			MODE_RAW: begin
				push(byte_level(b), SC_MONO8, 1'b0, 1'b1, e);
			end
			MODE_DATA: begin
				if (remaining != 0) begin
					bps = (bits == 16) ? 2 : 1;
					align = bps * ((chans == 2) ? 2 : 1);
					remaining--;
					if (pcount + 1 >= align) begin
						if (align == 1) begin
							num = byte_level(b);
							code = SC_MONO8;
						end else if (bps == 2 && align == 2) begin
							num = 2 * s16({b, partial[7:0]}) + 1;
							code = SC_MONO16;
						end else if (align == 2) begin
							num = byte_level(partial[7:0]) + byte_level(b);
							code = SC_STEREO8;
						end else begin
							num = s16(partial[15:0]) + s16({b, partial[23:16]}) + 1;
							code = SC_STEREO16;
						end
						push(num, code, 1'b1, 1'b1, e || remaining == 0);
						partial = '0;
						pcount = 0;
					end else begin
						partial = partial | (24'(b) << (8 * pcount));
						pcount++;
					end
				end
			end
			default: begin
				at = (pos >= HDR_LEN - 1) ? HDR_LEN - 1 : pos;
				hdr[at] = b;
				if (at == HDR_LEN - 1) begin
					if (header_passes()) begin
						phase = MODE_DATA;
						partial = '0;
						pcount = 0;
					end else begin
						replay(HDR_LEN, e);
						phase = MODE_RAW;
					end
				end else if (e) begin
					replay(at + 1, 1'b1);
				end else begin
					pos = at + 1;
				end
			end
			endcase
			if (e)
				clear();
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		task check_sample(sample_t got);
			sample_t want;
			if (expected.size() == 0) begin
				report($sformatf("unexpected sample numerator %0d", got.num));
				return;
			end
			want = expected.pop_front();
			if (got.num !== want.num)
				report($sformatf("numerator %0d, expected %0d", got.num, want.num));
			if (got.code !== want.code)
				report($sformatf("scale_code %0d, expected %0d", got.code, want.code));
			if (got.ok !== want.ok)
				report($sformatf("header_ok %b, expected %b", got.ok, want.ok));
			if (got.rl !== want.rl)
				report($sformatf("run_last %b, expected %b", got.rl, want.rl));
			if (got.sl !== want.sl)
				report($sformatf("stream_last %b, expected %b", got.sl, want.sl));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int idle_pct = 35;
	bit hold_tgl = 1'b0;
	int quiet = 0;
	logic [7:0] file_q [$];
	sample_t got;
	sample_board board;

	wdc_byte_if byte_bus();
	wdc_sample_if sample_bus();

	wav_header_check_pcm_downmix_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(byte_bus),
		.sample_out(sample_bus)
	);

	always #1 clk = ~clk;

	// receiver: random stalls, plus a long hold-off when requested
	initial begin
		int hold_left;
		bit seen;
		hold_left = 0;
		seen = 1'b0;
		sample_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_tgl != seen) begin
				seen = hold_tgl;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				sample_bus.ready <= 1'b0;
			end else begin
				sample_bus.ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_bus.valid && byte_bus.ready)
				board.note_byte(byte_bus.data_byte, byte_bus.file_end);
			if (sample_bus.valid && sample_bus.ready) begin
				got.num = sample_bus.sample_numerator;
				got.code = sample_bus.scale_code;
				got.ok = sample_bus.header_ok;
				got.rl = sample_bus.run_last;
				got.sl = sample_bus.stream_last;
				board.check_sample(got);
			end
			if ((byte_bus.valid && byte_bus.ready) || (sample_bus.valid && sample_bus.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
		0: return 8'h00;
		1: return 8'hFF;
		2: return 8'h80;
		3: return 8'h7F;
		default: return 8'($urandom);
		endcase
	endfunction

	function automatic int frame_bytes(int f);
		return ((f & 1) ? 2 : 1) * ((f >= 2) ? 2 : 1);
	endfunction

	function automatic void put_le(logic [31:0] v, int n);
		for (int i = 0; i < n; i++)
			file_q.push_back(v[8 * i +: 8]);
	endfunction

	function automatic void put_tag(logic [31:0] t);
		for (int i = 3; i >= 0; i--)
			file_q.push_back(t[8 * i +: 8]);
	endfunction

	// f: bit 0 selects 16-bit samples, bit 1 selects stereo
	function automatic void make_header(int f, logic [31:0] dlen);
		logic [31:0] rate, align;
		rate = $urandom;
		align = frame_bytes(f);
		put_tag("RIFF");
		put_le(dlen + 32'(RIFF_EXTRA), 4);
		put_tag("WAVE");
		put_tag("fmt ");
		put_le(32'd16, 4);
		put_le(32'd1, 2);
		put_le((f >= 2) ? 32'd2 : 32'd1, 2);
		put_le(rate, 4);
		put_le(rate * align, 4);
		put_le(align, 2);
		put_le((f & 1) ? 32'd16 : 32'd8, 2);
		put_tag("data");
		put_le(dlen, 4);
	endfunction

	function automatic void add_body(int n);
		for (int i = 0; i < n; i++)
			file_q.push_back(pick_byte());
	endfunction

	function automatic void build_file(int kind);
		int f, align, dlen, n;
		file_q.delete();
		f = $urandom_range(3);
		case (kind)
		0, 1, 2, 3: begin
			align = frame_bytes(kind);
			dlen = align * $urandom_range(0, 6);
			make_header(kind, dlen);
			case ($urandom_range(2))
			0: add_body(dlen);
			1: add_body(dlen + $urandom_range(1, 5));
			default: add_body($urandom_range(0, dlen));
			endcase
		end
		4: begin
			// declared length far beyond the file, the file end closes the stream
			make_header(f, 32'hFFFF_FFFC);
			add_body($urandom_range(1, 12));
		end
		5: begin
			make_header(f, frame_bytes(f) * $urandom_range(0, 4));
			n = $urandom_range(0, HDR_LEN - 1);
			file_q[n] = file_q[n] ^ 8'($urandom_range(1, 255));
			add_body($urandom_range(0, 20));
		end
		6: begin
			// data length not a whole number of frames
			f = $urandom_range(1, 3);
			make_header(f, frame_bytes(f) * $urandom_range(0, 4) + 1);
			add_body($urandom_range(0, 10));
		end
		7: begin
			n = $urandom_range(1, HDR_LEN - 1);
			if ($urandom_range(1)) begin
				make_header(f, frame_bytes(f));
				while (file_q.size() > n)
					void'(file_q.pop_back());
			end else begin
				add_body(n);
			end
		end
		8: begin
			add_body($urandom_range(1, 60));
		end
		default: begin
			// valid header with the file end on its last byte
			make_header(f, frame_bytes(f) * $urandom_range(0, 4));
		end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic e);
		while ($urandom_range(99) < idle_pct) begin
			byte_bus.valid <= 1'b0;
			@(posedge clk);
		end
		byte_bus.valid <= 1'b1;
		byte_bus.data_byte <= b;
		byte_bus.file_end <= e;
		@(posedge clk);
		while (!byte_bus.ready)
			@(posedge clk);
	endtask

	task automatic send_file();
		for (int i = 0; i < file_q.size(); i++)
			send_byte(file_q[i], i == file_q.size() - 1);
	endtask

	task automatic drain();
		byte_bus.valid <= 1'b0;
		@(posedge clk);
		while (board.expected.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int k, kind, nitems;
		arst_n = 1'b0;
		byte_bus.valid = 1'b0;
		byte_bus.data_byte = 8'h00;
		byte_bus.file_end = 1'b0;
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-byte files and a short file cut inside the size field after the first tag
		file_q = '{8'h00};
		send_file();
		file_q = '{8'hFF};
		send_file();
		file_q = '{8'h52, 8'h49, 8'h46, 8'h46, 8'h80, 8'h7F};
		send_file();
		nitems = 8;

		k = 0;
		while (nitems < ITEM_GOAL) begin
			kind = (k < 10) ? KIND_ORDER[k] : $urandom_range(9);
			idle_pct = (k == 2 || k == 3) ? 0 : 35;
			// invalid header: replay backs up behind a stalled receiver
			if (k == 0)
				hold_tgl = ~hold_tgl;
			build_file(kind);
			nitems += file_q.size();
			send_file();
			if (k == 1)
				drain();
			k++;
		end
		idle_pct = 35;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.expected.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
design/wdc_pkg.sv
design/wdc_byte_if.sv
design/wdc_sample_if.sv
design/wdc_ram.sv
design/wdc_fifo.sv
design/wdc_front.sv
design/wdc_back.sv
design/wav_header_check_pcm_downmix_core.sv
bench/wav_header_check_pcm_downmix_core_tb.sv
